// ===== design/uhv_pkg.sv =====
// ----------------------------------------------------------------------------
// uhv_pkg
// Types, constants and the byte-wide CRC step shared by the boot image
// header validator.
// ----------------------------------------------------------------------------
package uhv_pkg;

    localparam int unsigned HDR_LEN      = 64;
    localparam int unsigned POS_W        = 6;
    localparam logic [31:0] HDR_MAGIC    = 32'h2705_1956;
    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
    localparam logic [31:0] HDR_LEN_W    = 32'd64;

    // Header field offsets, in bytes from the start of the header.
    localparam logic [POS_W-1:0] MAGIC_OFFSET = 6'h00;
    localparam logic [POS_W-1:0] HCRC_OFFSET  = 6'h04;
    localparam logic [POS_W-1:0] SIZE_OFFSET  = 6'h0C;
    localparam logic [POS_W-1:0] LOAD_OFFSET  = 6'h10;
    localparam logic [POS_W-1:0] ENTRY_OFFSET = 6'h14;
    localparam logic [POS_W-1:0] LAST_POS     = 6'h3F;

    localparam int unsigned OUT_TDATA_W = 104;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_BAD_MAGIC = 3'd2,
        ST_ZERO_SIZE = 3'd3,
        ST_OVERRUN   = 3'd4,
        ST_CRC_BAD   = 3'd5
    } t_status;

    // One byte of the reflected CRC-32; the eight shifts flatten to an XOR network.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== design/uimage_header_validator_core.sv =====
// ----------------------------------------------------------------------------
// uimage_header_validator_core
// Checks the 64-byte header of a legacy boot image streamed one byte per
// request and reports the outcome together with size, load and entry words.
// ----------------------------------------------------------------------------
// Throughput: one header byte per cycle, set by the byte-wide CRC-32 update
// between the input register and the state registers; the last byte of a
// header is held while the previous result is still waiting. The result is
// registered once the 64th byte passes on from the input register.
// Reset (i_rst_n low, synchronous): clears the byte counter, the CRC to all
// ones, the gathered words, the length register and both valid flags.
// ----------------------------------------------------------------------------
module uimage_header_validator_core
    import uhv_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [31:0]            i_cfg_wr_data,    // available_length
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,     // [7:0] header_byte
    input  logic [0:0]             s_axis_tuser,     // [0] first_byte
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] header_ok, [3:1] status, [35:4] payload_size, [67:36] load_addr,
    // [99:68] entry_point, [103:100] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [31:0]      r_avail_len;

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_first;

    logic [POS_W-1:0] r_byte_count, n_byte_count;
    logic [31:0]      r_crc, n_crc;
    logic [31:0]      r_magic, n_magic;
    logic [31:0]      r_hcrc, n_hcrc;
    logic [31:0]      r_size, n_size;
    logic [31:0]      r_load, n_load;
    logic [31:0]      r_entry, n_entry;

    logic             r_out_valid;
    logic             r_out_ok;
    t_status          r_out_status;
    logic [31:0]      r_out_size;
    logic [31:0]      r_out_load;
    logic [31:0]      r_out_entry;

    logic [POS_W-1:0] w_pos;
    logic             w_is_last;
    logic             w_out_free;
    logic             w_advance;
    logic [31:0]      w_crc_in;
    logic [31:0]      w_crc_step;
    logic [7:0]       w_crc_data;
    t_status          w_status;

    assign w_pos      = r_in_first ? '0 : r_byte_count;
    assign w_is_last  = (w_pos == LAST_POS);
    assign w_out_free = !r_out_valid || m_axis_tready;
    // The byte in the input register moves on unless it would complete a header
    // while the previous result is still waiting.
    assign w_advance  = r_in_valid && (!w_is_last || w_out_free);

    assign s_axis_tready = !r_in_valid || w_advance;

    // The stored header CRC field is fed to the CRC as zeros.
    assign w_crc_in   = r_in_first ? CRC_INIT : r_crc;
    assign w_crc_data = (w_pos >= HCRC_OFFSET && w_pos < HCRC_OFFSET + 6'd4) ? 8'h00 : r_in_byte;
    assign w_crc_step = crc_byte(w_crc_in, w_crc_data);

    always_comb begin
        n_byte_count = w_pos + 6'd1;
        n_crc        = w_is_last ? CRC_INIT : w_crc_step;
        n_magic      = r_magic;
        n_hcrc       = r_hcrc;
        n_size       = r_size;
        n_load       = r_load;
        n_entry      = r_entry;
        if (w_pos < HCRC_OFFSET) begin
            n_magic = {r_magic[23:0], r_in_byte};
        end else if (w_pos < HCRC_OFFSET + 6'd4) begin
            n_hcrc = {r_hcrc[23:0], r_in_byte};
        end else if (w_pos >= SIZE_OFFSET && w_pos < SIZE_OFFSET + 6'd4) begin
            n_size = {r_size[23:0], r_in_byte};
        end else if (w_pos >= LOAD_OFFSET && w_pos < LOAD_OFFSET + 6'd4) begin
            n_load = {r_load[23:0], r_in_byte};
        end else if (w_pos >= ENTRY_OFFSET && w_pos < ENTRY_OFFSET + 6'd4) begin
            n_entry = {r_entry[23:0], r_in_byte};
        end
    end

    // The last byte falls outside every gathered field, so the words are final.
    always_comb begin
        if (r_avail_len < HDR_LEN_W) begin
            w_status = ST_SHORT;
        end else if (r_magic != HDR_MAGIC) begin
            w_status = ST_BAD_MAGIC;
        end else if (r_size == 32'd0) begin
            w_status = ST_ZERO_SIZE;
        end else if (r_size > (r_avail_len - HDR_LEN_W)) begin
            w_status = ST_OVERRUN;
        end else if (r_hcrc != ~w_crc_step) begin
            w_status = ST_CRC_BAD;
        end else begin
            w_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avail_len <= '0;
        end else if (i_cfg_wr_en) begin
            r_avail_len <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte  <= s_axis_tdata;
            r_in_first <= s_axis_tuser[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_crc        <= CRC_INIT;
            r_magic      <= '0;
            r_hcrc       <= '0;
            r_size       <= '0;
            r_load       <= '0;
            r_entry      <= '0;
        end else if (w_advance) begin
            r_byte_count <= n_byte_count;
            r_crc        <= n_crc;
            r_magic      <= n_magic;
            r_hcrc       <= n_hcrc;
            r_size       <= n_size;
            r_load       <= n_load;
            r_entry      <= n_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_is_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_is_last) begin
            r_out_ok     <= (w_status == ST_OK);
            r_out_status <= w_status;
            r_out_size   <= r_size;
            r_out_load   <= r_load;
            r_out_entry  <= r_entry;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out_entry, r_out_load, r_out_size, r_out_status, r_out_ok};

    // A completed header always leaves the counter and CRC ready for the next one.
    a_restart_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && w_is_last |=> (r_byte_count == '0) && (r_crc == CRC_INIT))
        else $error("counter or CRC not restarted after the last header byte");

    // A last byte held back by a waiting result must still be there next cycle.
    a_last_byte_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && w_is_last && !w_out_free |=> r_in_valid && $stable(r_in_byte))
        else $error("last header byte lost while the result was stalled");

    // The pass flag and the status code must agree.
    a_ok_matches_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_out_ok == (r_out_status == ST_OK)))
        else $error("header_ok disagrees with status");

endmodule
